@@ sv/assert_macros.svh @@
// Shared assertion macros, clocked on clk and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/hmpf_pkg.sv @@
`default_nettype none

package hmpf_pkg;

  localparam int LENGTH_BITS  = 20;
  localparam int BYTE_W       = 8;
  localparam int FILL_W       = 6;
  localparam int PART_W       = 16;
  localparam int SEQ_W        = 16;
  localparam int CMD_W        = 16;
  localparam int FMT_W        = 2;
  localparam int IDX_W        = 6;
  localparam int POS_W        = IDX_W + 1;
  localparam int PACKET_BYTES = 64;
  localparam int IN_TDATA_W   = ((CMD_W + LENGTH_BITS + BYTE_W + 7) / 8) * 8;

  localparam int DEF_FIRST_PAYLOAD = 42;
  localparam int DEF_NEXT_PAYLOAD  = 54;
  localparam int HDR_BYTES         = 8;
  localparam int FIRST_HDR_BYTES   = 12;

  localparam int QDEPTH  = 2;
  localparam int QSLOT_W = 1;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PACKET_BYTES - 1);

  localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'h3f;
  localparam logic [BYTE_W-1:0] TYPE_FIRST = 8'h5d;
  localparam logic [BYTE_W-1:0] TYPE_NEXT  = 8'h5e;

  localparam logic [15:0] CRC_INIT = 16'hffff;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [15:0] DIR_NORMAL     = 16'h0005;
  localparam logic [15:0] DIR_LEGACY_ONE = 16'h0001;
  localparam logic [15:0] DIR_LEGACY_TWO = 16'h0015;
  localparam logic [15:0] FMT_NORMAL     = 16'h0009;
  localparam logic [15:0] FMT_LEGACY_ONE = 16'h0000;

  localparam logic [FMT_W-1:0] LEGACY_NORMAL = 2'd0;
  localparam logic [FMT_W-1:0] LEGACY_ONE    = 2'd1;
  localparam logic [FMT_W-1:0] LEGACY_TWO    = 2'd2;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_DATA  = 1'b1;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_LEGACY_FORMAT    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_SEQUENCE = 1'd1;

  typedef struct packed {
    logic                   first;
    logic                   last;
    logic [FILL_W-1:0]      n;
    logic [PART_W-1:0]      parts;
    logic [CMD_W-1:0]       cmd;
    logic [LENGTH_BITS-1:0] len;
    logic [SEQ_W-1:0]       seq;
    logic [FMT_W-1:0]       legacy;
  } pkt_desc_t;

  typedef struct packed {
    logic               we;
    logic [QSLOT_W-1:0] bank;
    logic [FILL_W-1:0]  addr;
    logic [BYTE_W-1:0]  data;
  } store_wr_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [BYTE_W-1:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ sv/hid_message_packet_framer.sv @@
// After the item that completes a packet (or a zero-length start), the descriptor is
// queued and the idle back end leaves B_IDLE and registers byte 0; the 64 bytes then
// follow one a cycle while m_tready is high.
// Throughput: one input transfer a cycle while a packet bank is free (two banks) and
// no part-count multiply is pending; the output returns to idle between packets. A
// start with more than one packet holds s_tready low for the multiply. Synchronous
// reset clears control state, sequence and format; the packet banks are not cleared.
`default_nettype none

module hid_message_packet_framer import hmpf_pkg::*; #(
  parameter int FIRST_PAYLOAD = DEF_FIRST_PAYLOAD,
  parameter int NEXT_PAYLOAD  = DEF_NEXT_PAYLOAD
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // command_code, message_length, payload_byte, zero pad
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  // req_type
  input  wire logic [0:0]             s_tuser,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // packet_byte
  output logic [BYTE_W-1:0]           m_tdata,
  output logic                        m_tlast,
  // message_end
  output logic [0:0]                  m_tuser,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic               push, pop, q_full, q_empty;
  logic [QSLOT_W-1:0] wr_slot, rd_slot;
  pkt_desc_t          push_desc, head;
  store_wr_t          store_wr;

  hmpf_front #(
    .FIRST_PAYLOAD (FIRST_PAYLOAD),
    .NEXT_PAYLOAD  (NEXT_PAYLOAD)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .wr_slot   (wr_slot),
    .push      (push),
    .push_desc (push_desc),
    .store_wr  (store_wr)
  );

  hmpf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full),
    .wr_slot   (wr_slot),
    .rd_slot   (rd_slot)
  );

  hmpf_back #(
    .FIRST_PAYLOAD (FIRST_PAYLOAD),
    .NEXT_PAYLOAD  (NEXT_PAYLOAD)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .store_wr (store_wr),
    .head     (head),
    .empty    (q_empty),
    .rd_slot  (rd_slot),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

@@ sv/hmpf_front.sv @@
`default_nettype none

module hmpf_front import hmpf_pkg::*; #(
  parameter int FIRST_PAYLOAD = DEF_FIRST_PAYLOAD,
  parameter int NEXT_PAYLOAD  = DEF_NEXT_PAYLOAD
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  input  wire logic [0:0]             s_tuser,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   q_full,
  input  wire logic [QSLOT_W-1:0]     wr_slot,
  output logic                        push,
  output pkt_desc_t                   push_desc,
  output store_wr_t                   store_wr
);

  `include "assert_macros.svh"

  localparam int DW = LENGTH_BITS + 1;
  localparam int RS = DW + 7;
  localparam int MW = RS + 1;
  localparam longint RM = ((longint'(1) << RS) + longint'(NEXT_PAYLOAD - 1)) /
                          longint'(NEXT_PAYLOAD);
  localparam logic [MW-1:0] RECIP = MW'(RM);

  typedef enum logic [1:0] {
    F_RUN = 2'b01,
    F_DIV = 2'b10
  } front_state_t;

  front_state_t           state;
  logic                   open;
  logic                   first_part;
  logic [FILL_W-1:0]      fill;
  logic [LENGTH_BITS-1:0] remaining;
  logic [PART_W-1:0]      part_index;
  logic [PART_W-1:0]      part_total;
  logic [CMD_W-1:0]       held_cmd;
  logic [LENGTH_BITS-1:0] held_len;
  logic [SEQ_W-1:0]       seq;
  logic [FMT_W-1:0]       legacy;
  logic [DW-1:0]          dvd;

  logic                   req_type;
  logic [CMD_W-1:0]       in_cmd;
  logic [LENGTH_BITS-1:0] in_len;
  logic [BYTE_W-1:0]      in_byte;
  logic                   accept, start_ok, is_data, zero_start;
  logic                   data_last, data_push;
  logic [FILL_W-1:0]      fill_inc, cap;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic [DW+MW-1:0]       prod;

  assign req_type = s_tuser[0];
  assign in_cmd   = s_tdata[CMD_W-1:0];
  assign in_len   = s_tdata[CMD_W +: LENGTH_BITS];
  assign in_byte  = s_tdata[CMD_W + LENGTH_BITS +: BYTE_W];

  assign s_tready   = (state == F_RUN) && !q_full;
  assign accept     = s_tvalid && s_tready;
  assign start_ok   = accept && (req_type == REQ_START) && !open;
  assign is_data    = accept && (req_type == REQ_DATA) && open;
  assign zero_start = start_ok && (in_len == '0);

  assign fill_inc  = fill + FILL_W'(1);
  assign rem_dec   = remaining - LENGTH_BITS'(1);
  assign cap       = first_part ? FILL_W'(FIRST_PAYLOAD) : FILL_W'(NEXT_PAYLOAD);
  assign data_last = (rem_dec == '0);
  assign data_push = is_data && (data_last || (fill_inc >= cap));
  assign push      = data_push || zero_start;

  always_comb begin
    push_desc.first  = zero_start ? 1'b1 : first_part;
    push_desc.last   = zero_start ? 1'b1 : data_last;
    push_desc.n      = zero_start ? '0 : fill_inc;
    push_desc.parts  = zero_start ? PART_W'(1) : (first_part ? part_total : part_index);
    push_desc.cmd    = zero_start ? in_cmd : held_cmd;
    push_desc.len    = zero_start ? in_len : held_len;
    push_desc.seq    = seq;
    push_desc.legacy = legacy;
  end

  assign store_wr.we   = is_data;
  assign store_wr.bank = wr_slot;
  assign store_wr.addr = fill;
  assign store_wr.data = in_byte;

  // part count by reciprocal multiply, exact over the whole dividend range
  assign prod = (DW+MW)'(dvd) * (DW+MW)'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_RUN;
      open       <= 1'b0;
      first_part <= 1'b0;
      fill       <= '0;
      remaining  <= '0;
      part_index <= '0;
      part_total <= '0;
      seq        <= '0;
      legacy     <= LEGACY_NORMAL;
    end else begin
      unique case (state)
        F_RUN: begin
          if (start_ok) begin
            held_cmd   <= in_cmd;
            held_len   <= in_len;
            remaining  <= in_len;
            part_index <= '0;
            fill       <= '0;
            first_part <= 1'b1;
            if (zero_start) begin
              part_total <= PART_W'(1);
              seq        <= seq + SEQ_W'(1);
            end else if (in_len > LENGTH_BITS'(FIRST_PAYLOAD)) begin
              open  <= 1'b1;
              dvd   <= DW'(in_len) - DW'(FIRST_PAYLOAD) + DW'(NEXT_PAYLOAD - 1);
              state <= F_DIV;
            end else begin
              open       <= 1'b1;
              part_total <= PART_W'(1);
            end
          end
          if (is_data) begin
            fill      <= data_push ? '0 : fill_inc;
            remaining <= rem_dec;
            if (data_push) begin
              part_index <= part_index + PART_W'(1);
              first_part <= 1'b0;
            end
            if (data_last) begin
              open <= 1'b0;
              seq  <= seq + SEQ_W'(1);
            end
          end
        end
        F_DIV: begin
          part_total <= prod[RS +: PART_W] + PART_W'(1);
          state      <= F_RUN;
        end
        default: state <= F_RUN;
      endcase
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LEGACY_FORMAT:    legacy <= cfg_data[FMT_W-1:0];
          REG_INITIAL_SEQUENCE: seq    <= cfg_data[SEQ_W-1:0];
          default: ;
        endcase
      end
    end
  end

  `ASSERT_ALWAYS(a_fill_below_cap, !open || (fill < cap), "fill passed packet capacity")
  `ASSERT_NEXT(a_div_in_open_msg, state == F_DIV, open, "part count divide without open message")

endmodule

`default_nettype wire

@@ sv/hmpf_queue.sv @@
`default_nettype none

module hmpf_queue import hmpf_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire pkt_desc_t           push_desc,
  input  wire logic                pop,
  output pkt_desc_t                head,
  output logic                     empty,
  output logic                     full,
  output logic [QSLOT_W-1:0]       wr_slot,
  output logic [QSLOT_W-1:0]       rd_slot
);

  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(QDEPTH + 1);

  pkt_desc_t           slots [QDEPTH];
  logic [QSLOT_W-1:0]  wr_ptr;
  logic [QSLOT_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]    count;

  assign empty   = (count == '0);
  assign full    = (count == CNT_W'(QDEPTH));
  assign wr_slot = wr_ptr;
  assign rd_slot = rd_ptr;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QSLOT_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QSLOT_W'(1);
      unique case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_no_overflow, !(push && full), "packet queue overflow")
  `ASSERT_ALWAYS(a_no_underflow, !(pop && empty), "packet queue underflow")

endmodule

`default_nettype wire

@@ sv/hmpf_back.sv @@
`default_nettype none

module hmpf_back import hmpf_pkg::*; #(
  parameter int FIRST_PAYLOAD = DEF_FIRST_PAYLOAD,
  parameter int NEXT_PAYLOAD  = DEF_NEXT_PAYLOAD
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire store_wr_t           store_wr,
  input  wire pkt_desc_t           head,
  input  wire logic                empty,
  input  wire logic [QSLOT_W-1:0]  rd_slot,
  output logic                     pop,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [BYTE_W-1:0]        m_tdata,
  output logic                     m_tlast,
  output logic [0:0]               m_tuser
);

  `include "assert_macros.svh"

  localparam int DEPTH = (FIRST_PAYLOAD > NEXT_PAYLOAD) ? FIRST_PAYLOAD : NEXT_PAYLOAD;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_SEND = 2'b10
  } back_state_t;

  logic [BYTE_W-1:0] store [QDEPTH][DEPTH];

  back_state_t       state;
  logic [IDX_W-1:0]  idx;
  logic [15:0]       crc;
  logic [BYTE_W-1:0] rd_data;

  logic              adv;
  logic [IDX_W-1:0]  idx_next;
  logic [POS_W-1:0]  pos, pos_next, ml, base, pl_end, crc_pos, rd_diff;
  logic [AW-1:0]     rd_off;
  logic [3:0]        hdr_off;
  logic [15:0]       dir_word, fmt_word;
  logic [31:0]       len_word;
  logic [BYTE_W-1:0] byte_out;
  logic              crc_feed;

  assign adv      = (state == B_SEND) && (!m_tvalid || m_tready);
  assign pop      = adv && (idx == IDX_LAST);
  assign idx_next = adv ? idx + IDX_W'(1) : idx;

  assign pos      = POS_W'(idx);
  assign pos_next = POS_W'(idx_next);
  assign ml       = head.first ? POS_W'(head.n) + POS_W'(FIRST_HDR_BYTES) : POS_W'(head.n);
  assign base     = head.first ? POS_W'(HDR_BYTES + FIRST_HDR_BYTES) : POS_W'(HDR_BYTES);
  assign pl_end   = base + POS_W'(head.n);
  assign crc_pos  = ml + POS_W'(HDR_BYTES);
  assign hdr_off  = 4'(idx - IDX_W'(HDR_BYTES));
  assign len_word = 32'(head.len);

  // read runs one byte ahead so the registered data lines up with idx
  assign rd_diff = pos_next - base;
  assign rd_off  = ((pos_next >= base) && (rd_diff < POS_W'(DEPTH))) ? AW'(rd_diff) : '0;

  always_ff @(posedge clk) begin
    if (store_wr.we) begin
      store[store_wr.bank][store_wr.addr[AW-1:0]] <= store_wr.data;
    end
    rd_data <= store[rd_slot][rd_off];
  end

  always_comb begin
    unique case (head.legacy)
      LEGACY_ONE: begin
        dir_word = DIR_LEGACY_ONE;
        fmt_word = FMT_LEGACY_ONE;
      end
      LEGACY_TWO: begin
        dir_word = DIR_LEGACY_TWO;
        fmt_word = FMT_NORMAL;
      end
      default: begin
        dir_word = DIR_NORMAL;
        fmt_word = FMT_NORMAL;
      end
    endcase
  end

  always_comb begin
    unique case (idx)
      6'd0: byte_out = SYNC_BYTE;
      6'd1: byte_out = 8'(crc_pos);
      6'd2: byte_out = head.first ? TYPE_FIRST : TYPE_NEXT;
      6'd3: byte_out = 8'(ml);
      6'd4: byte_out = head.parts[7:0];
      6'd5: byte_out = head.parts[15:8];
      6'd6: byte_out = crc[7:0];
      6'd7: byte_out = crc[15:8];
      default: begin
        priority if (head.first && (pos < base)) begin
          unique case (hdr_off)
            4'd0:    byte_out = head.cmd[15:8];
            4'd1:    byte_out = head.cmd[7:0];
            4'd2:    byte_out = dir_word[7:0];
            4'd3:    byte_out = dir_word[15:8];
            4'd4:    byte_out = fmt_word[7:0];
            4'd5:    byte_out = fmt_word[15:8];
            4'd6:    byte_out = head.seq[7:0];
            4'd7:    byte_out = head.seq[15:8];
            4'd8:    byte_out = len_word[7:0];
            4'd9:    byte_out = len_word[15:8];
            4'd10:   byte_out = len_word[23:16];
            4'd11:   byte_out = len_word[31:24];
            default: byte_out = '0;
          endcase
        end else if (pos < pl_end) begin
          byte_out = rd_data;
        end else if (pos == crc_pos) begin
          byte_out = crc[7:0];
        end else if (pos == crc_pos + POS_W'(1)) begin
          byte_out = crc[15:8];
        end else begin
          byte_out = '0;
        end
      end
    endcase
  end

  // header CRC over bytes 2..5, then over first-packet header and payload
  assign crc_feed = ((pos >= POS_W'(2)) && (pos <= POS_W'(5))) ||
                    ((pos >= POS_W'(HDR_BYTES)) && (pos < crc_pos));

  always_ff @(posedge clk) begin
    if (adv) begin
      if (idx == IDX_W'(1)) begin
        crc <= CRC_INIT;
      end else if (crc_feed) begin
        crc <= crc_byte(crc, byte_out);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      idx      <= '0;
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
      m_tuser  <= '0;
    end else begin
      unique case (state)
        B_IDLE: begin
          idx <= '0;
          if (!empty) state <= B_SEND;
        end
        B_SEND: begin
          idx <= idx_next;
          if (pop) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
      if (adv) begin
        m_tvalid   <= 1'b1;
        m_tdata    <= byte_out;
        m_tlast    <= (idx == IDX_LAST);
        m_tuser[0] <= (idx == IDX_LAST) && head.last;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `ASSERT_NEXT(a_pop_on_packet_end, pop, m_tvalid && m_tlast, "packet retired off its last byte")

endmodule

`default_nettype wire
